// ===== hw/rtl/lap_stopwatch_defines.svh =====
// assertion macros for the stopwatch block
`ifndef LAP_STOPWATCH_DEFINES_SVH
`define LAP_STOPWATCH_DEFINES_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define LSW_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lap_stopwatch: invariant violated");

// consequent holds in the same cycle as the antecedent
`define LSW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lap_stopwatch: implication violated");

// consequent holds in the cycle after the antecedent
`define LSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lap_stopwatch: next-cycle check violated");

`else

`define LSW_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define LSW_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LSW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/lsw_pkg.sv =====
// shared types and constants of the stopwatch block
package lsw_pkg;

    // time held in mixed radix: hours, minutes, seconds, hundredths
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [6:0] centis;
    } t_time;

    // tick step split into whole seconds and hundredths
    typedef struct packed {
        logic [3:0] secs;
        logic [6:0] centis;
    } t_step;

    // request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_KEYS = 1'b1;

    // key bit positions
    localparam int KEY_PAUSE     = 0;
    localparam int KEY_RESET     = 1;
    localparam int KEY_LAP       = 2;
    localparam int KEY_CLEAR_LAP = 3;

    // radix limits
    localparam logic [7:0] CENTIS_PER_SEC = 8'd100;
    localparam logic [6:0] SECS_PER_MIN   = 7'd60;
    localparam logic [6:0] MINS_PER_HOUR  = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY  = 6'd24;

    // wrap points of the lap count and the colour
    localparam logic [13:0] LAP_CNT_LAST = 14'd9999;
    localparam logic [2:0]  COLOUR_LAST  = 3'd6;

    // step split: floor(v / 100) == (v * 41) >> 12 for every 10-bit v
    localparam logic [5:0]  STEP_RECIP_MUL = 6'd41;
    localparam int          STEP_RECIP_SH  = 12;
    localparam logic [10:0] STEP_CS_MUL    = 11'd100;

    // reset values
    localparam logic [15:0] PREV_KEYS_RST = 16'd16;
    localparam t_step       STEP_RST      = '{secs: 4'd1, centis: 7'd0};

endpackage

// ===== hw/rtl/lsw_req_if.sv =====
// request channel: tick or key scan beats
interface lsw_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] keys;

    modport source (output valid, output req_type, output keys, input ready);
    modport sink   (input valid, input req_type, input keys, output ready);
endinterface

// ===== hw/rtl/lsw_res_if.sv =====
// result channel: time, lap and display status beats
interface lsw_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  lap_hours;
    logic [5:0]  lap_minutes;
    logic [5:0]  lap_seconds;
    logic        lap_shown;
    logic [13:0] lap_total;
    logic [2:0]  colour;
    logic        running;

    modport source (
        output valid, output hours, output minutes, output seconds,
        output lap_hours, output lap_minutes, output lap_seconds,
        output lap_shown, output lap_total, output colour, output running,
        input ready
    );
    modport sink (
        input valid, input hours, input minutes, input seconds,
        input lap_hours, input lap_minutes, input lap_seconds,
        input lap_shown, input lap_total, input colour, input running,
        output ready
    );
endinterface

// ===== hw/rtl/lsw_cfg.sv =====
// tick step register, stored pre-split into seconds and hundredths
module lsw_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [9:0]     i_cfg_data,
    output lsw_pkg::t_step o_step
);

    logic [15:0]    w_prod;
    logic [3:0]     w_secs;
    logic [10:0]    w_sec_counts;
    logic [9:0]     w_centis;
    lsw_pkg::t_step r_step;
    lsw_pkg::t_step n_step;

    // divide by 100 through the reciprocal, remainder by subtraction
    always_comb begin
        w_prod       = 16'(i_cfg_data) * 16'(lsw_pkg::STEP_RECIP_MUL);
        w_secs       = w_prod[15:lsw_pkg::STEP_RECIP_SH];
        w_sec_counts = 11'(w_secs) * lsw_pkg::STEP_CS_MUL;
        w_centis     = i_cfg_data - w_sec_counts[9:0];
        n_step.secs   = w_secs;
        n_step.centis = w_centis[6:0];
    end

    // step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= lsw_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

// ===== hw/rtl/lsw_core.sv =====
// input register, single-pass state update and result handshake
module lsw_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lsw_pkg::t_step i_step,
    lsw_req_if.sink        i_req,
    lsw_res_if.source      o_res
);

    `include "lap_stopwatch_defines.svh"

    // input register
    logic        r_in_valid;
    logic        r_in_type;
    logic [15:0] r_in_keys;

    // result valid; the state registers are the result payload
    logic        r_out_valid;

    // stopwatch state
    lsw_pkg::t_time r_time;
    lsw_pkg::t_time r_lap;
    logic [13:0]    r_lap_cnt;
    logic [2:0]     r_colour;
    logic           r_run;
    logic [15:0]    r_prev_keys;

    lsw_pkg::t_time n_time;
    lsw_pkg::t_time n_lap;
    logic [13:0]    n_lap_cnt;
    logic [2:0]     n_colour;
    logic           n_run;
    logic [15:0]    n_prev_keys;

    logic           w_advance;
    lsw_pkg::t_time w_tick_time;

    // tick adder internals
    logic [7:0] w_cs_sum;
    logic       w_cs_carry;
    logic [6:0] w_s_sum;
    logic       w_s_carry;
    logic [6:0] w_m_sum;
    logic       w_m_carry;
    logic [5:0] w_h_sum;

    // a beat moves out of the input register when the result slot frees up
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_type <= i_req.req_type;
            r_in_keys <= i_req.keys;
        end
    end

    // mixed-radix add of the step, wrapping at 24 hours
    always_comb begin
        w_cs_sum   = 8'(r_time.centis) + 8'(i_step.centis);
        w_cs_carry = (w_cs_sum >= lsw_pkg::CENTIS_PER_SEC);
        w_tick_time.centis = w_cs_carry ? 7'(w_cs_sum - lsw_pkg::CENTIS_PER_SEC)
                                        : w_cs_sum[6:0];

        w_s_sum   = 7'(r_time.seconds) + 7'(i_step.secs) + 7'(w_cs_carry);
        w_s_carry = (w_s_sum >= lsw_pkg::SECS_PER_MIN);
        w_tick_time.seconds = w_s_carry ? 6'(w_s_sum - lsw_pkg::SECS_PER_MIN)
                                        : w_s_sum[5:0];

        w_m_sum   = 7'(r_time.minutes) + 7'(w_s_carry);
        w_m_carry = (w_m_sum == lsw_pkg::MINS_PER_HOUR);
        w_tick_time.minutes = w_m_carry ? 6'd0 : w_m_sum[5:0];

        w_h_sum = 6'(r_time.hours) + 6'(w_m_carry);
        w_tick_time.hours = (w_h_sum == lsw_pkg::HOURS_PER_DAY) ? 5'd0 : w_h_sum[4:0];
    end

    // next state for the beat in the input register
    always_comb begin
        n_time      = r_time;
        n_lap       = r_lap;
        n_lap_cnt   = r_lap_cnt;
        n_colour    = r_colour;
        n_run       = r_run;
        n_prev_keys = r_prev_keys;
        if (r_in_type == lsw_pkg::REQ_TICK) begin
            if (r_run) begin
                n_time = w_tick_time;
            end
        end else if (r_in_keys != r_prev_keys) begin
            n_prev_keys = r_in_keys;
            if (r_in_keys[lsw_pkg::KEY_PAUSE]) begin
                n_run = !r_run;
            end
            if (r_in_keys[lsw_pkg::KEY_RESET]) begin
                n_time = '0;
                n_run  = 1'b0;
            end
            // lap only on a nonzero count, after any clear above
            if (r_in_keys[lsw_pkg::KEY_LAP] && (n_time != '0)) begin
                n_lap     = n_time;
                n_lap_cnt = (r_lap_cnt == lsw_pkg::LAP_CNT_LAST) ? 14'd0
                                                                 : r_lap_cnt + 14'd1;
                n_colour  = (r_colour == lsw_pkg::COLOUR_LAST) ? 3'd0 : r_colour + 3'd1;
            end
            if (r_in_keys[lsw_pkg::KEY_CLEAR_LAP]) begin
                n_lap = '0;
            end
        end
    end

    // state update, only when the result slot takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_lap       <= '0;
            r_lap_cnt   <= '0;
            r_colour    <= '0;
            r_run       <= 1'b0;
            r_prev_keys <= lsw_pkg::PREV_KEYS_RST;
        end else if (w_advance) begin
            r_time      <= n_time;
            r_lap       <= n_lap;
            r_lap_cnt   <= n_lap_cnt;
            r_colour    <= n_colour;
            r_run       <= n_run;
            r_prev_keys <= n_prev_keys;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result beat straight from the state
    assign o_res.valid       = r_out_valid;
    assign o_res.hours       = r_time.hours;
    assign o_res.minutes     = r_time.minutes;
    assign o_res.seconds     = r_time.seconds;
    assign o_res.lap_hours   = r_lap.hours;
    assign o_res.lap_minutes = r_lap.minutes;
    assign o_res.lap_seconds = r_lap.seconds;
    assign o_res.lap_shown   = (r_lap != '0);
    assign o_res.lap_total   = r_lap_cnt;
    assign o_res.colour      = r_colour;
    assign o_res.running     = r_run;

    // time digits stay within their radix
    `LSW_ASSERT_ALWAYS(a_time_range, i_clk, i_rst_n, (r_time.centis < 7'd100) && (r_time.seconds < 6'd60) && (r_time.minutes < 6'd60) && (r_time.hours < 5'd24))

    // lap count and colour stay within their wrap points
    `LSW_ASSERT_ALWAYS(a_wrap_range, i_clk, i_rst_n, (r_lap_cnt <= lsw_pkg::LAP_CNT_LAST) && (r_colour <= lsw_pkg::COLOUR_LAST))

    // a held result keeps the state frozen
    `LSW_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, r_out_valid && !o_res.ready, $stable(r_time) && $stable(r_lap) && $stable(r_run))

    // a tick while stopped leaves the time alone
    `LSW_ASSERT_NEXT(a_stopped_tick, i_clk, i_rst_n, w_advance && (r_in_type == lsw_pkg::REQ_TICK) && !r_run, $stable(r_time))

    // a repeated key word changes nothing
    `LSW_ASSERT_NEXT(a_same_keys, i_clk, i_rst_n, w_advance && (r_in_type == lsw_pkg::REQ_KEYS) && (r_in_keys == r_prev_keys), $stable(r_time) && $stable(r_lap) && $stable(r_lap_cnt) && $stable(r_colour) && $stable(r_run))

endmodule

// ===== hw/rtl/lap_stopwatch.sv =====
// top level of the lap stopwatch
//
//  channel   dir  handshake      content
//  i_req     in   valid/ready    req_type, keys
//  o_res     out  valid/ready    running time, lap time, lap_shown, lap_total, colour, running
//  cfg       in   i_cfg_we       tick_step in i_cfg_data
//
// One beat per cycle while the result is not stalled: each beat is captured in the
// input register, the state update is a single pass of adders and compares, and
// the state registers and result valid load from it when the result slot frees up.
// A stalled result holds the state; one more beat waits in the input register.
// Synchronous active-low reset clears the state and sets the step to 100.
module lap_stopwatch (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_data,
    lsw_req_if.sink    i_req,
    lsw_res_if.source  o_res
);

    lsw_pkg::t_step w_step;

    // step register
    lsw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_step     (w_step)
    );

    // datapath and handshake
    lsw_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule
